/* design/rit_pkg.sv */
// Shared types and constants for the refcounted intern table.
package rit_pkg;

   localparam int TABLE_DEPTH_DEF = 256;
   localparam int KEY_BYTES_DEF   = 8;

   localparam logic [31:0] FNV_BASIS = 32'd2166136261;
   localparam logic [31:0] FNV_PRIME = 32'd16777619;
   localparam logic [31:0] IDENT_MAX = 32'hFFFF_FFFF;
   localparam logic [31:0] REFS_MAX  = 32'hFFFF_FFFF;

   typedef enum logic [1:0] {
      KIND_INTERN  = 2'd0,
      KIND_ADDREF  = 2'd1,
      KIND_RELEASE = 2'd2,
      KIND_FIND    = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_FOUND   = 3'd0,
      ST_NEW     = 3'd1,
      ST_MISSING = 3'd2,
      ST_FULL    = 3'd3,
      ST_FREED   = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      FIN_NONE = 3'd0,
      FIN_UPD  = 3'd1,
      FIN_NEW  = 3'd2,
      FIN_MISS = 3'd3,
      FIN_FULL = 3'd4
   } finish_type;

   typedef struct packed {
      logic       load;
      logic       idx_clr;
      logic       idx_inc;
      logic       idx_from_rem;
      logic       rd_en;
      logic       step_clr;
      logic       step_inc;
      logic       hash_init;
      logic       hash_step;
      logic       mod_step;
      logic       slot_take;
      logic       cand_load;
      logic       cand_inc;
      finish_type finish;
   } cmd_type;

   typedef struct packed {
      kind_type in_kind;
      logic     in_ident_zero;
      logic     last_idx;
      logic     key_hit;
      logic     id_hit;
      logic     cand_hit;
      logic     hash_last;
      logic     mod_last;
      logic     probe_free;
      logic     probe_last;
      logic     rsp_free;
   } stat_type;

endpackage

/* design/rit_req_if.sv */
// Request channel interface: operation kind, key and identifier.
interface rit_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [63:0] key;
   logic [31:0] ident;

   modport source (output valid, output kind, output key, output ident, input ready);
   modport sink   (input valid, input kind, input key, input ident, output ready);
endinterface

/* design/rit_rsp_if.sv */
// Response channel interface: status, identifier, count, key and usage.
interface rit_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [31:0] ident_out;
   logic [31:0] ref_count;
   logic [63:0] key_out;
   logic [8:0]  entries_used;

   modport source (output valid, output status, output ident_out, output ref_count,
                   output key_out, output entries_used, input ready);
   modport sink   (input valid, input status, input ident_out, input ref_count,
                   input key_out, input entries_used, output ready);
endinterface

/* design/rit_ctrl.sv */
// Controller state machine sequencing scans, hashing, probing and responses.
module rit_ctrl
   import rit_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   typedef enum logic [13:0] {
      S_IDLE  = 14'b00000000000001,
      S_KRD   = 14'b00000000000010,
      S_KCMP  = 14'b00000000000100,
      S_HASH  = 14'b00000000001000,
      S_MOD   = 14'b00000000010000,
      S_PROBE = 14'b00000000100000,
      S_ARD   = 14'b00000001000000,
      S_ACMP  = 14'b00000010000000,
      S_IRD   = 14'b00000100000000,
      S_ICMP  = 14'b00001000000000,
      S_UPD   = 14'b00010000000000,
      S_NEW   = 14'b00100000000000,
      S_MISS  = 14'b01000000000000,
      S_FULL  = 14'b10000000000000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      cmd.finish = FIN_NONE;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load    = 1'b1;
               cmd.idx_clr = 1'b1;
               if (stat.in_kind == KIND_INTERN) state_in = S_KRD;
               else if (stat.in_ident_zero)     state_in = S_MISS;
               else                             state_in = S_IRD;
            end
         end
         S_KRD: begin
            cmd.rd_en = 1'b1;
            state_in  = S_KCMP;
         end
         S_KCMP: begin
            if (stat.key_hit) begin
               cmd.slot_take = 1'b1;
               state_in      = S_UPD;
            end else if (stat.last_idx) begin
               cmd.hash_init = 1'b1;
               cmd.step_clr  = 1'b1;
               state_in      = S_HASH;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = S_KRD;
            end
         end
         S_HASH: begin
            cmd.hash_step = 1'b1;
            if (stat.hash_last) begin
               cmd.step_clr = 1'b1;
               state_in     = S_MOD;
            end else begin
               cmd.step_inc = 1'b1;
            end
         end
         S_MOD: begin
            cmd.mod_step = 1'b1;
            if (stat.mod_last) begin
               cmd.idx_from_rem = 1'b1;
               cmd.step_clr     = 1'b1;
               state_in         = S_PROBE;
            end else begin
               cmd.step_inc = 1'b1;
            end
         end
         S_PROBE: begin
            if (stat.probe_free) begin
               cmd.slot_take = 1'b1;
               cmd.cand_load = 1'b1;
               cmd.idx_clr   = 1'b1;
               state_in      = S_ARD;
            end else if (stat.probe_last) begin
               state_in = S_FULL;
            end else begin
               cmd.idx_inc  = 1'b1;
               cmd.step_inc = 1'b1;
            end
         end
         S_ARD: begin
            cmd.rd_en = 1'b1;
            state_in  = S_ACMP;
         end
         S_ACMP: begin
            if (stat.cand_hit) begin
               cmd.cand_inc = 1'b1;
               cmd.idx_clr  = 1'b1;
               state_in     = S_ARD;
            end else if (stat.last_idx) begin
               state_in = S_NEW;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = S_ARD;
            end
         end
         S_IRD: begin
            cmd.rd_en = 1'b1;
            state_in  = S_ICMP;
         end
         S_ICMP: begin
            if (stat.id_hit) begin
               cmd.slot_take = 1'b1;
               state_in      = S_UPD;
            end else if (stat.last_idx) begin
               state_in = S_MISS;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = S_IRD;
            end
         end
         S_UPD: begin
            if (stat.rsp_free) begin
               cmd.finish = FIN_UPD;
               state_in   = S_IDLE;
            end
         end
         S_NEW: begin
            if (stat.rsp_free) begin
               cmd.finish = FIN_NEW;
               state_in   = S_IDLE;
            end
         end
         S_MISS: begin
            if (stat.rsp_free) begin
               cmd.finish = FIN_MISS;
               state_in   = S_IDLE;
            end
         end
         S_FULL: begin
            if (stat.rsp_free) begin
               cmd.finish = FIN_FULL;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

/* design/rit_dp.sv */
// Datapath: entry memory, valid bits, hash unit, modulo unit, counters and response register.
module rit_dp
   import rit_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
   parameter int KEY_BYTES   = KEY_BYTES_DEF
)(
   input  logic        clock,
   input  logic        reset,
   input  logic [1:0]  in_kind,
   input  logic [63:0] in_key,
   input  logic [31:0] in_ident,
   input  cmd_type     cmd,
   output stat_type    stat,
   input  logic        rsp_ready,
   output logic        rsp_valid,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_ident,
   output logic [31:0] rsp_refs,
   output logic [63:0] rsp_key,
   output logic [8:0]  rsp_used
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int LW    = $clog2(TABLE_DEPTH + 1);
   localparam int SW    = (LW > 6) ? LW : 6;
   localparam logic [63:0] KEY_MASK = {64{1'b1}} >> (64 - 8 * KEY_BYTES);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_DEPTH - 1);
   // ceil(2^(32+IDX_W) / depth): exact quotient for any 32-bit hash
   localparam logic [63:0] RECIP_W = ((64'd1 << (32 + IDX_W)) + 64'(TABLE_DEPTH) - 64'd1)
                                     / 64'(TABLE_DEPTH);
   localparam logic [32:0] RECIP   = RECIP_W[32:0];
   localparam logic [31:0] DEPTH_W = 32'(TABLE_DEPTH);

   typedef struct packed {
      logic [63:0] key;
      logic [31:0] refs;
      logic [31:0] ident;
   } entry_type;

   entry_type mem [TABLE_DEPTH];
   entry_type rd_ff;
   logic [TABLE_DEPTH-1:0] valid_ff;

   kind_type          kind_ff;
   logic [63:0]       key_ff;
   logic [31:0]       ident_ff;
   logic [IDX_W-1:0]  idx_ff, slot_ff;
   logic [SW-1:0]     step_ff;
   logic [31:0]       hash_ff, hash_in;
   logic [64:0]       prod_ff, quo_wide;
   logic [31:0]       quo, rem_in;
   logic [31:0]       cand_ff, cand_nx, next_ident_ff;
   logic [LW-1:0]     live_ff, live_in;
   logic [LW+8:0]     live_wide;
   logic [7:0]        hbyte;
   logic [31:0]       new_refs;
   logic              freed;
   logic              wr_en;
   entry_type         wr_data;
   logic [IDX_W-1:0]  wr_addr;

   logic        rsp_valid_ff;
   status_type  rsp_status_ff;
   logic [31:0] rsp_ident_ff, rsp_refs_ff;
   logic [63:0] rsp_key_ff;
   logic [8:0]  rsp_used_ff;

   assign hbyte    = 8'(key_ff >> {step_ff[2:0], 3'b000});
   assign hash_in  = (hash_ff ^ {24'd0, hbyte}) * FNV_PRIME;
   assign quo_wide = prod_ff >> (32 + IDX_W);
   assign quo      = quo_wide[31:0];
   assign rem_in   = hash_ff - quo * DEPTH_W;
   assign cand_nx  = (cand_ff == IDENT_MAX) ? 32'd1 : cand_ff + 32'd1;

   always_comb begin
      freed    = 1'b0;
      new_refs = rd_ff.refs;
      case (kind_ff)
         KIND_INTERN, KIND_ADDREF: begin
            if (rd_ff.refs != REFS_MAX) new_refs = rd_ff.refs + 32'd1;
         end
         KIND_RELEASE: begin
            if (rd_ff.refs != 32'd0) new_refs = rd_ff.refs - 32'd1;
            freed = (new_refs == 32'd0);
         end
         default: new_refs = rd_ff.refs;
      endcase
   end

   always_comb begin
      live_in = live_ff;
      wr_en   = 1'b0;
      wr_addr = slot_ff;
      wr_data = '{key: key_ff, refs: 32'd1, ident: cand_ff};
      if (cmd.finish == FIN_NEW) begin
         wr_en   = 1'b1;
         live_in = live_ff + LW'(1);
      end else if (cmd.finish == FIN_UPD) begin
         wr_en   = 1'b1;
         wr_data = '{key: rd_ff.key, refs: new_refs, ident: rd_ff.ident};
         if (freed && live_ff != '0) live_in = live_ff - LW'(1);
      end
   end

   assign live_wide = {9'd0, live_in};

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (cmd.rd_en) rd_ff <= mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff  <= kind_type'(in_kind);
         key_ff   <= in_key & KEY_MASK;
         ident_ff <= in_ident;
      end
      if (cmd.idx_clr)           idx_ff <= '0;
      else if (cmd.idx_from_rem) idx_ff <= rem_in[IDX_W-1:0];
      else if (cmd.idx_inc)      idx_ff <= (idx_ff == IDX_LAST) ? '0 : idx_ff + IDX_W'(1);
      if (cmd.step_clr)      step_ff <= '0;
      else if (cmd.step_inc) step_ff <= step_ff + SW'(1);
      if (cmd.hash_init)      hash_ff <= FNV_BASIS;
      else if (cmd.hash_step) hash_ff <= hash_in;
      if (cmd.mod_step) prod_ff <= {33'd0, hash_ff} * {32'd0, RECIP};
      if (cmd.slot_take) slot_ff <= idx_ff;
      if (cmd.cand_load)     cand_ff <= next_ident_ff;
      else if (cmd.cand_inc) cand_ff <= cand_nx;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         next_ident_ff <= 32'd1;
         live_ff       <= '0;
      end else begin
         live_ff <= live_in;
         if (cmd.finish == FIN_NEW) begin
            valid_ff[slot_ff] <= 1'b1;
            next_ident_ff     <= cand_nx;
         end else if (cmd.finish == FIN_UPD && freed) begin
            valid_ff[slot_ff] <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish != FIN_NONE) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish != FIN_NONE) begin
         rsp_used_ff <= live_wide[8:0];
         case (cmd.finish)
            FIN_UPD: begin
               rsp_status_ff <= freed ? ST_FREED : ST_FOUND;
               rsp_ident_ff  <= rd_ff.ident;
               rsp_refs_ff   <= new_refs;
               rsp_key_ff    <= rd_ff.key;
            end
            FIN_NEW: begin
               rsp_status_ff <= ST_NEW;
               rsp_ident_ff  <= cand_ff;
               rsp_refs_ff   <= 32'd1;
               rsp_key_ff    <= key_ff;
            end
            FIN_FULL: begin
               rsp_status_ff <= ST_FULL;
               rsp_ident_ff  <= '0;
               rsp_refs_ff   <= '0;
               rsp_key_ff    <= '0;
            end
            default: begin
               rsp_status_ff <= ST_MISSING;
               rsp_ident_ff  <= '0;
               rsp_refs_ff   <= '0;
               rsp_key_ff    <= '0;
            end
         endcase
      end
   end

   always_comb begin
      stat.in_kind       = kind_type'(in_kind);
      stat.in_ident_zero = (in_ident == 32'd0);
      stat.last_idx      = (idx_ff == IDX_LAST);
      stat.key_hit       = valid_ff[idx_ff] && (rd_ff.key == key_ff);
      stat.id_hit        = valid_ff[idx_ff] && (rd_ff.ident == ident_ff);
      stat.cand_hit      = valid_ff[idx_ff] && (rd_ff.ident == cand_ff);
      stat.hash_last     = (step_ff == SW'(KEY_BYTES - 1));
      stat.mod_last      = (step_ff == SW'(1));
      stat.probe_free    = !valid_ff[idx_ff];
      stat.probe_last    = (step_ff == SW'(TABLE_DEPTH - 1));
      stat.rsp_free      = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_ident  = rsp_ident_ff;
   assign rsp_refs   = rsp_refs_ff;
   assign rsp_key    = rsp_key_ff;
   assign rsp_used   = rsp_used_ff;

endmodule

/* design/refcounted_intern_table_top.sv */
// Top level of the refcounted intern table: controller plus datapath.
//
// Requests arrive on req_bus (kind, key, ident); one response per request
// leaves on rsp_bus (status, ident_out, ref_count, key_out, entries_used).
// A beat moves on either channel when valid and ready are both high.
// One request is worked at a time; req_bus.ready is high only while idle.
// Work per request, from accept to response valid:
//   ident 0 (not intern): straight to a miss response.
//   add-ref / release / find, intern of a live key: a read and compare
//   per entry until a hit or the last entry, then a finish step.
//   intern of a new key: key scan, hash over the key bytes, modulo, probe
//   for a free slot (else full), a scan per candidate ident, finish.
// The next request can be taken in the same cycle the response turns valid.
// The response sits in an output register; if the receiver stalls, the
// finished request waits there and the next request may still be accepted.
// Reset clears valid bits, the live count and sets the next identifier
// to 1; no clearing pass over the memory is needed.
module refcounted_intern_table_top
   import rit_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
   parameter int KEY_BYTES   = KEY_BYTES_DEF
)(
   input  logic   clock,
   input  logic   reset,
   rit_req_if.sink   req_bus,
   rit_rsp_if.source rsp_bus
);

   cmd_type  cmd;
   stat_type stat;
   logic     req_ready;

   assign req_bus.ready = req_ready;

   rit_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   rit_dp #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .KEY_BYTES   (KEY_BYTES)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .in_kind    (req_bus.kind),
      .in_key     (req_bus.key),
      .in_ident   (req_bus.ident),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_ready  (rsp_bus.ready),
      .rsp_valid  (rsp_bus.valid),
      .rsp_status (rsp_bus.status),
      .rsp_ident  (rsp_bus.ident_out),
      .rsp_refs   (rsp_bus.ref_count),
      .rsp_key    (rsp_bus.key_out),
      .rsp_used   (rsp_bus.entries_used)
   );

endmodule
